>>> sv/smss_pkg.sv
// Shared types and constants for the sample mix/scale/saturate block.
// Used by every stage module and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package smss_pkg;

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int SUM_W    = 26;  // signed sum of two widened samples
  localparam int MAG_W    = 25;  // magnitude of that sum
  localparam int GAIN_W   = 24;  // unsigned Q8.16
  localparam int FRAC_W   = 16;
  localparam int FULL_W   = MAG_W + GAIN_W;
  localparam int PROD_W   = FULL_W - FRAC_W;

  // sample format codes
  localparam logic [1:0] FMT_8  = 2'd0;
  localparam logic [1:0] FMT_16 = 2'd1;
  localparam logic [1:0] FMT_24 = 2'd2;

  // operation codes
  localparam logic OP_MIX   = 1'b0;
  localparam logic OP_SCALE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_SIGNED = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 24'h010000;

  typedef struct packed {
    logic [1:0]        fmt;
    logic              sgn;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  // front stage result: sign and magnitude of the sum
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic             last;
  } front_t;

  // scale stage result: truncated scaled magnitude
  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] prod;
    logic              last;
  } scale_t;

endpackage

`default_nettype wire

>>> sv/smss_front.sv
// Front stage: widens both samples, adds them in mix mode, splits sign and magnitude.
// Depends on smss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smss_front import smss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [SAMPLE_W-1:0] source,
  input  logic [SAMPLE_W-1:0] dest,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_ready,
  output front_t              out_data
);

  logic signed [SUM_W-1:0] src_ext;
  logic signed [SUM_W-1:0] dst_ext;
  logic signed [SUM_W-1:0] sum;
  logic        [SUM_W-1:0] mag_full;
  logic                    valid;
  front_t                  data;

  // widen a raw sample by format and signedness
  function automatic logic [SUM_W-1:0] widen(input logic [SAMPLE_W-1:0] raw,
                                             input logic [1:0] fmt,
                                             input logic sgn);
    logic [SUM_W-1:0] ext;
    case (fmt)
      FMT_8:   ext = {{(SUM_W-8){sgn & raw[7]}}, raw[7:0]};
      FMT_16:  ext = {{(SUM_W-16){sgn & raw[15]}}, raw[15:0]};
      default: ext = {{(SUM_W-SAMPLE_W){sgn & raw[SAMPLE_W-1]}}, raw};
    endcase
    return ext;
  endfunction

  // sum and magnitude
  always_comb begin
    src_ext  = widen(source, cfg.fmt, cfg.sgn);
    dst_ext  = widen(dest, cfg.fmt, cfg.sgn);
    sum      = (op == OP_MIX) ? (src_ext + dst_ext) : src_ext;
    mag_full = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      data.neg  <= sum[SUM_W-1];
      data.mag  <= mag_full[MAG_W-1:0];
      data.last <= last;
    end
  end

endmodule

`default_nettype wire

>>> sv/smss_scale.sv
// Scale stage: multiplies the magnitude by the Q8.16 gain and drops the fraction bits.
// Depends on smss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smss_scale import smss_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output scale_t out_data
);

  logic [FULL_W-1:0] prod_full;
  logic              valid;
  scale_t            data;

  // 25 x 24 bit unsigned product, truncation of magnitude is toward zero
  assign prod_full = FULL_W'(in_data.mag) * FULL_W'(cfg.gain);

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      data.neg  <= in_data.neg;
      data.prod <= prod_full[FULL_W-1:FRAC_W];
      data.last <= in_data.last;
    end
  end

endmodule

`default_nettype wire

>>> sv/smss_sat.sv
// Saturation stage: restores the sign, clamps to the format range and repacks.
// Holds the output register; depends on smss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smss_sat import smss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  scale_t              in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_sample,
  output logic                out_last
);

  logic [PROD_W-1:0]   half;
  logic [PROD_W-1:0]   full;
  logic [PROD_W-1:0]   lim_pos;
  logic [PROD_W-1:0]   neg_val;
  logic [SAMPLE_W-1:0] res;
  logic                valid;
  logic [SAMPLE_W-1:0] sample;
  logic                last;

  // format limits
  always_comb begin
    case (cfg.fmt)
      FMT_8:   half = PROD_W'(33'h80);
      FMT_16:  half = PROD_W'(33'h8000);
      default: half = PROD_W'(33'h800000);
    endcase
    full    = (half << 1) - PROD_W'(1);
    lim_pos = cfg.sgn ? (half - PROD_W'(1)) : full;
    neg_val = -in_data.prod;
  end

  // clamp and mask
  always_comb begin
    if (!in_data.neg) begin
      res = (in_data.prod > lim_pos) ? lim_pos[SAMPLE_W-1:0] : in_data.prod[SAMPLE_W-1:0];
    end else if (!cfg.sgn) begin
      res = '0;
    end else begin
      res = (in_data.prod > half) ? half[SAMPLE_W-1:0] : neg_val[SAMPLE_W-1:0];
    end
    res = res & full[SAMPLE_W-1:0];
  end

  assign in_ready   = !valid || out_ready;
  assign out_valid  = valid;
  assign out_sample = sample;
  assign out_last   = last;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      sample <= res;
      last   <= in_data.last;
    end
  end

endmodule

`default_nettype wire

>>> sv/sample_mix_scale_saturate.sv
// Top level of the sample mix/scale/saturate block: config registers and three stages.
// Depends on smss_pkg, smss_front, smss_scale and smss_sat.
`timescale 1ns / 1ps
`default_nettype none

// Mixes two 8, 16 or 24 bit audio samples (or takes the source alone in scale
// mode), multiplies by an unsigned Q8.16 gain truncating toward zero, and
// saturates the result to the configured format, signed or unsigned. One item
// is accepted per clock while the output is not stalled; each item passes
// through the three registered stages (add and magnitude, 25 x 24 bit
// multiply, clamp into the output register) before its result appears. Back
// pressure on the output stalls the stages only as far as they are full.
// After reset the format is 16 bit signed with unity gain. Configuration is
// written through the cfg channel, which is always ready, and must only be
// changed while no item is in flight.

module sample_mix_scale_saturate import smss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [GAIN_W-1:0]     cfg_data,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [2*SAMPLE_W-1:0] s_tdata,   // [23:0] source_sample, [47:24] dest_sample
  input  logic                  s_tuser,   // [0] operation
  input  logic                  s_tlast,
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [SAMPLE_W-1:0]   m_tdata,   // [23:0] mixed_sample
  output logic                  m_tlast
);

  cfg_t   cfg;
  logic   f_valid;
  logic   f_ready;
  front_t f_data;
  logic   sc_valid;
  logic   sc_ready;
  scale_t sc_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt  <= FMT_16;
      cfg.sgn  <= 1'b1;
      cfg.gain <= GAIN_UNITY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORMAT: cfg.fmt  <= cfg_data[1:0];
        REG_SIGNED: cfg.sgn  <= cfg_data[0];
        REG_GAIN:   cfg.gain <= cfg_data;
        default:    ;
      endcase
    end
  end

  // add and magnitude
  smss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .op        (s_tuser),
    .source    (s_tdata[SAMPLE_W-1:0]),
    .dest      (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .last      (s_tlast),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  // gain multiply
  smss_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_data  (sc_data)
  );

  // clamp and output register
  smss_sat u_sat (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (sc_valid),
    .in_ready   (sc_ready),
    .in_data    (sc_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (m_tdata),
    .out_last   (m_tlast)
  );

  // unsigned samples never produce a negative sum
  a_unsigned_nonneg: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !cfg.sgn) |=> !f_data.neg)
    else $error("negative sum for unsigned format");

  // unity gain passes the magnitude through unchanged
  a_unity_gain: assert property (@(posedge clk) disable iff (rst)
    (f_valid && f_ready && cfg.gain == GAIN_UNITY) |=>
      (sc_data.prod == PROD_W'($past(f_data.mag))))
    else $error("unity gain changed the magnitude");

  // 8 bit results keep the upper bits clear
  a_fmt8_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (sc_valid && sc_ready && cfg.fmt == FMT_8) |=> (m_tdata[SAMPLE_W-1:8] == '0))
    else $error("8 bit result has upper bits set");

  // 16 bit results keep the upper byte clear
  a_fmt16_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (sc_valid && sc_ready && cfg.fmt == FMT_16) |=> (m_tdata[SAMPLE_W-1:16] == '0))
    else $error("16 bit result has upper bits set");

endmodule

`default_nettype wire
